// ===== rtl/xkx_pkg.sv =====
// Shared constants, codes and types for the XXTEA keystream XOR block.
// No dependencies; the other files except xkx_ram refer to it by scoped names.
package xkx_pkg;

	localparam int unsigned DataW          = 32;
	localparam int unsigned NumKeyParts    = 4;
	localparam int unsigned CfgIndexW      = 2;

	localparam int unsigned KeyWordsDef    = 1024;
	localparam int unsigned SecureWordsDef = 512;
	localparam int unsigned SparseStrideDef = 64;
	localparam int unsigned ChecksumWordsDef = 128;
	localparam int unsigned KeyRoundsDef   = 6;

	localparam logic [DataW-1:0] MixDelta  = 32'h9e37_79b9;

	// request opcodes
	localparam logic CmdGenerate = 1'b0;
	localparam logic CmdProcess  = 1'b1;

	typedef logic [NumKeyParts-1:0][DataW-1:0] key_set_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_status_t;

	typedef struct packed {
		logic             xored;
		logic [DataW-1:0] checksum;
	} strm_info_t;

endpackage

// ===== rtl/xkx_ram.sv =====
// Generic single-port synchronous RAM, registered read, read-before-write.
// No dependencies.
module xkx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic [AddrW-1:0] addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/xkx_gen.sv =====
// Keystream generator: XXTEA encoding rounds over the table in RAM.
// Uses xkx_pkg; drives the RAM port while busy.
module xkx_gen #(
	parameter int unsigned KEY_WORDS  = xkx_pkg::KeyWordsDef,
	parameter int unsigned KEY_ROUNDS = xkx_pkg::KeyRoundsDef,
	localparam int unsigned AddrW  = $clog2(KEY_WORDS),
	localparam int unsigned RoundW = (KEY_ROUNDS > 1) ? $clog2(KEY_ROUNDS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  xkx_pkg::key_set_t          key,
	input  logic [xkx_pkg::DataW-1:0]  ram_rdata,
	output logic [AddrW-1:0]           ram_addr,
	output logic                       ram_we,
	output logic [xkx_pkg::DataW-1:0]  ram_wdata,
	output xkx_pkg::gen_status_t       status
);

	localparam logic [1:0] G_IDLE = 2'd0;
	localparam logic [1:0] G_READ = 2'd1;
	localparam logic [1:0] G_CALC = 2'd2;

	localparam logic [AddrW-1:0]  LastPos   = AddrW'(KEY_WORDS - 1);
	localparam logic [RoundW-1:0] LastRound = RoundW'(KEY_ROUNDS - 1);

	logic [1:0]                  state_q;
	logic [AddrW-1:0]            pos_q;
	logic [RoundW-1:0]           round_q;
	logic [xkx_pkg::DataW-1:0]   sum_q, z_q, yprev_q;

	logic                        last_pos;
	logic [xkx_pkg::DataW-1:0]   y, mix_a, mix_b, new_word;
	logic [1:0]                  sel;

	always_comb begin
		last_pos = (pos_q == LastPos);
		// round 0: entries ahead of pos are still cleared
		y        = (round_q == '0 && !last_pos) ? '0 : ram_rdata;
		sel      = 2'(pos_q) ^ sum_q[3:2];
		mix_a    = ((z_q >> 5) ^ (y << 2)) + ((y >> 3) ^ (z_q << 4));
		mix_b    = (sum_q ^ y) + (key[sel] ^ z_q);
		// old value of entry pos is the y read on the previous step
		new_word = yprev_q + (mix_a ^ mix_b);

		ram_addr  = (state_q == G_READ) ? (last_pos ? '0 : AddrW'(pos_q + 1'b1)) : pos_q;
		ram_we    = (state_q == G_CALC);
		ram_wdata = new_word;

		status.busy = (state_q != G_IDLE);
		status.done = (state_q == G_CALC) && last_pos && (round_q == LastRound);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			pos_q   <= '0;
			round_q <= '0;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						pos_q   <= '0;
						round_q <= '0;
						state_q <= G_READ;
					end
				end
				G_READ: begin
					state_q <= G_CALC;
				end
				G_CALC: begin
					if (last_pos) begin
						pos_q <= '0;
						if (round_q == LastRound) begin
							state_q <= G_IDLE;
						end else begin
							round_q <= RoundW'(round_q + 1'b1);
							state_q <= G_READ;
						end
					end else begin
						pos_q   <= AddrW'(pos_q + 1'b1);
						state_q <= G_READ;
					end
				end
				default: begin
					state_q <= G_IDLE;
				end
			endcase
		end
	end

	// working values
	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && start) begin
			sum_q   <= xkx_pkg::MixDelta;
			z_q     <= '0;
			yprev_q <= '0;
		end else if (state_q == G_CALC) begin
			z_q     <= new_word;
			yprev_q <= y;
			if (last_pos) begin
				sum_q <= sum_q + xkx_pkg::MixDelta;
			end
		end
	end

endmodule

// ===== rtl/xkx_stream.sv =====
// Stream position counters, keystream index and running checksum.
// Uses xkx_pkg; advanced once per accepted data word.
module xkx_stream #(
	parameter int unsigned KEY_WORDS      = xkx_pkg::KeyWordsDef,
	parameter int unsigned SECURE_WORDS   = xkx_pkg::SecureWordsDef,
	parameter int unsigned SPARSE_STRIDE  = xkx_pkg::SparseStrideDef,
	parameter int unsigned CHECKSUM_WORDS = xkx_pkg::ChecksumWordsDef,
	localparam int unsigned AddrW = $clog2(KEY_WORDS),
	localparam int unsigned CountLimit = (SECURE_WORDS > CHECKSUM_WORDS) ?
		SECURE_WORDS : CHECKSUM_WORDS,
	localparam int unsigned CountW = $clog2(CountLimit + 1),
	localparam int unsigned PhaseW = (SPARSE_STRIDE > 1) ? $clog2(SPARSE_STRIDE) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       first,
	input  logic [xkx_pkg::DataW-1:0]  data_word,
	output logic [AddrW-1:0]           key_addr,
	output xkx_pkg::strm_info_t        info,
	output logic [xkx_pkg::DataW-1:0]  cur_checksum
);

	localparam logic [AddrW-1:0] LastKey = AddrW'(KEY_WORDS - 1);

	logic [CountW-1:0]          wc_q, wc, wc_next;
	logic [PhaseW-1:0]          sp_q, sp, sp_next;
	logic [AddrW-1:0]           ki_q, ki, ki_next;
	logic [xkx_pkg::DataW-1:0]  cs_q, cs, cs_next;
	logic                       secure, xored;
	logic [31:0]                sp_inc;

	always_comb begin
		wc = first ? '0 : wc_q;
		sp = first ? '0 : sp_q;
		ki = first ? '0 : ki_q;
		cs = first ? '0 : cs_q;

		cs_next = (32'(wc) < CHECKSUM_WORDS) ? (cs ^ data_word) : cs;
		secure  = (32'(wc) < SECURE_WORDS);
		xored   = secure || (sp == '0);

		sp_inc  = 32'(sp) + 32'd1;
		if (secure) begin
			sp_next = sp;
		end else begin
			sp_next = (sp_inc >= SPARSE_STRIDE) ? '0 : PhaseW'(sp_inc);
		end

		if (xored) begin
			ki_next = (ki == LastKey) ? '0 : AddrW'(ki + 1'b1);
		end else begin
			ki_next = ki;
		end

		wc_next = (32'(wc) < CountLimit) ? CountW'(wc + 1'b1) : wc;

		key_addr       = ki;
		info.xored     = xored;
		info.checksum  = cs_next;
		cur_checksum   = cs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			sp_q <= '0;
			ki_q <= '0;
			cs_q <= '0;
		end else if (step) begin
			wc_q <= wc_next;
			sp_q <= sp_next;
			ki_q <= ki_next;
			cs_q <= cs_next;
		end
	end

endmodule

// ===== rtl/xxtea_keystream_xor_encryptor.sv =====
// Top level of the XXTEA keystream XOR block: request handshake, key registers,
// keystream RAM, generator and stream counters. Uses xkx_pkg, xkx_ram, xkx_gen, xkx_stream.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | in_valid / in_ready  | cmd, data_word, first, last
//  result   | out_valid / out_ready| out_word, checksum, was_xored, done_last
//  config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// For a data-word request, the accept cycle addresses the keystream RAM, and its
// registered read data is XORed in the next cycle into the result register.
// A generate request runs KEY_ROUNDS rounds over all KEY_WORDS entries:
// each step reads one entry and writes one back through the single RAM port.
// Reset is asynchronous: keys, counters and checksum clear; the table is masked to
// zero by a flag until the first generate, so no clearing pass is run.
// in_ready is low while a request is in flight or while a result waits in the
// output register and out_ready is low.
module xxtea_keystream_xor_encryptor #(
	parameter int unsigned KEY_WORDS      = xkx_pkg::KeyWordsDef,
	parameter int unsigned SECURE_WORDS   = xkx_pkg::SecureWordsDef,
	parameter int unsigned SPARSE_STRIDE  = xkx_pkg::SparseStrideDef,
	parameter int unsigned CHECKSUM_WORDS = xkx_pkg::ChecksumWordsDef,
	parameter int unsigned KEY_ROUNDS     = xkx_pkg::KeyRoundsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [xkx_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [xkx_pkg::DataW-1:0]      cfg_data,
	// requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [xkx_pkg::DataW-1:0]      data_word,
	input  logic                           first,
	input  logic                           last,
	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [xkx_pkg::DataW-1:0]      out_word,
	output logic [xkx_pkg::DataW-1:0]      checksum,
	output logic                           was_xored,
	output logic                           done_last
);

	localparam int unsigned AddrW = $clog2(KEY_WORDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;	// waiting on keystream read
	localparam logic [1:0] ST_GEN  = 2'd2;	// generator owns the RAM

	logic [1:0]                 state_q;
	xkx_pkg::key_set_t          key_q;
	logic                       table_valid_q;

	logic                       accept, step, gen_start;
	logic [AddrW-1:0]           ram_addr, gen_addr, strm_addr;
	logic                       ram_we, gen_we;
	logic [xkx_pkg::DataW-1:0]  ram_wdata, gen_wdata, ram_rdata, ks_word;
	xkx_pkg::gen_status_t       gen_status;
	xkx_pkg::strm_info_t        strm_info;
	logic [xkx_pkg::DataW-1:0]  cur_checksum;

	// request held for the lookup cycle
	logic [xkx_pkg::DataW-1:0]  word_s1;
	logic                       last_s1;
	xkx_pkg::strm_info_t        info_s1;

	// result register
	logic                       out_valid_q;
	logic [xkx_pkg::DataW-1:0]  out_word_q, checksum_q;
	logic                       was_xored_q, done_last_q;
	logic                       load_look, load_gen;

	// --- handshake ---
	// Only take a request when the result slot is free, or frees this cycle.
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign step      = accept && (cmd == xkx_pkg::CmdProcess);
	assign gen_start = accept && (cmd == xkx_pkg::CmdGenerate);

	assign load_look = (state_q == ST_LOOK);
	assign load_gen  = (state_q == ST_GEN) && gen_status.done;

	// --- configuration ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	// --- keystream RAM, shared by generator and stream lookups ---
	always_comb begin
		if (gen_status.busy) begin
			ram_addr  = gen_addr;
			ram_we    = gen_we;
			ram_wdata = gen_wdata;
		end else begin
			ram_addr  = strm_addr;
			ram_we    = 1'b0;
			ram_wdata = gen_wdata;
		end
	end

	xkx_ram #(
		.WIDTH (xkx_pkg::DataW),
		.DEPTH (KEY_WORDS)
	) u_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Before the first generate the table reads as all zero.
	assign ks_word = table_valid_q ? ram_rdata : '0;

	xkx_gen #(
		.KEY_WORDS  (KEY_WORDS),
		.KEY_ROUNDS (KEY_ROUNDS)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (gen_start),
		.key       (key_q),
		.ram_rdata (ram_rdata),
		.ram_addr  (gen_addr),
		.ram_we    (gen_we),
		.ram_wdata (gen_wdata),
		.status    (gen_status)
	);

	xkx_stream #(
		.KEY_WORDS      (KEY_WORDS),
		.SECURE_WORDS   (SECURE_WORDS),
		.SPARSE_STRIDE  (SPARSE_STRIDE),
		.CHECKSUM_WORDS (CHECKSUM_WORDS)
	) u_stream (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.first        (first),
		.data_word    (data_word),
		.key_addr     (strm_addr),
		.info         (strm_info),
		.cur_checksum (cur_checksum)
	);

	// --- control ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (step) begin
						state_q <= ST_LOOK;
					end else if (gen_start) begin
						state_q <= ST_GEN;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
				end
				ST_GEN: begin
					if (gen_status.done) begin
						table_valid_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			word_s1 <= data_word;
			last_s1 <= last;
			info_s1 <= strm_info;
		end
	end

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_look || load_gen) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_look) begin
			out_word_q  <= info_s1.xored ? (word_s1 ^ ks_word) : word_s1;
			checksum_q  <= info_s1.checksum;
			was_xored_q <= info_s1.xored;
			done_last_q <= last_s1;
		end else if (load_gen) begin
			out_word_q  <= '0;
			checksum_q  <= cur_checksum;
			was_xored_q <= 1'b0;
			done_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign checksum  = checksum_q;
	assign was_xored = was_xored_q;
	assign done_last = done_last_q;

endmodule

// ===== rtl/xkx_checker.sv =====
// Port-level checks for xxtea_keystream_xor_encryptor, attached by bind.
// Uses xkx_pkg for widths and opcodes.
module xkx_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           cmd,
	input logic [xkx_pkg::DataW-1:0]      data_word,
	input logic                           first,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [xkx_pkg::DataW-1:0]      out_word,
	input logic [xkx_pkg::DataW-1:0]      checksum,
	input logic                           was_xored,
	input logic                           done_last
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another was in flight");

	// a data word yields its result after the keystream read and the result register
	a_word_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == xkx_pkg::CmdProcess |-> ##2 out_valid)
		else $error("data word result not presented on time");

	// first word of a stream restarts the checksum at that word
	a_first_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == xkx_pkg::CmdProcess && first
		|-> ##2 (checksum == $past(data_word, 2)))
		else $error("checksum not restarted by first word");

	// generate never answers in the following cycle
	a_gen_not_immediate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == xkx_pkg::CmdGenerate |=> !out_valid)
		else $error("generate result appeared too early");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(checksum)
			&& $stable(was_xored) && $stable(done_last))
		else $error("stalled result changed");

endmodule

bind xxtea_keystream_xor_encryptor xkx_checker u_xkx_checker (.*);
